// ----- design/sbsr_pkg.sv -----
// Package for the servo-bus status receiver: item kinds, input word and
// result word types shared by the stage modules. No dependencies.
`default_nettype none

package sbsr_pkg;

    // Kind of an input word
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2
    } kind_t;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [8:0]  IDX_ID        = 9'd2;
    localparam logic [8:0]  IDX_LEN       = 9'd3;
    localparam logic [8:0]  IDX_ERR       = 9'd4;
    localparam logic [8:0]  IDX_PARAM_A   = 9'd5;
    localparam logic [8:0]  IDX_PARAM_B   = 9'd6;
    localparam logic [7:0]  SUM_GOOD      = 8'hFF;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    // One input word
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } item_t;

    // One result word
    typedef struct packed {
        logic       timed_out;
        logic       checksum_ok;
        logic [7:0] device_id;
        logic [7:0] length_field;
        logic [7:0] error_byte;
        logic [7:0] first_param;
        logic [7:0] second_param;
    } result_t;

endpackage

`default_nettype wire

// ----- design/sbsr_in_stage.sv -----
// Input register of the servo-bus status receiver: holds one accepted word
// until the core takes it. Depends on sbsr_pkg.
`default_nettype none

module sbsr_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire sbsr_pkg::item_t s_item,
    input  wire logic           take,
    output logic                item_valid,
    output sbsr_pkg::item_t     item
);

    logic            valid_reg, valid_next;
    sbsr_pkg::item_t item_reg;

    // Accept when empty or when the held word leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- design/sbsr_core.sv -----
// Packet state and decode of the servo-bus status receiver: byte count,
// checksum, captured fields and inter-byte timeout. Depends on sbsr_pkg.
`default_nettype none

module sbsr_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            take,
    input  wire sbsr_pkg::item_t item,
    output logic                 res_valid,
    output sbsr_pkg::result_t    res
);

    logic        receiving_reg, receiving_next;
    logic [8:0]  index_reg, index_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  err_reg, err_next;
    logic [7:0]  pa_reg, pa_next;
    logic [7:0]  pb_reg, pb_next;
    logic [15:0] timeout_reg;

    logic [7:0]  len_eff;
    logic [8:0]  last_index;
    logic [15:0] ticks_inc;
    logic [7:0]  sum_plus;

    assign len_eff    = (index_reg == sbsr_pkg::IDX_LEN) ? item.rx_byte : len_reg;
    assign last_index = {1'b0, len_eff} + sbsr_pkg::IDX_LEN;
    assign ticks_inc  = (ticks_reg == sbsr_pkg::TICKS_MAX) ? ticks_reg : ticks_reg + 16'd1;
    assign sum_plus   = sum_reg + item.rx_byte;

    // Next packet state and result for the word taken this cycle
    always_comb begin
        receiving_next = receiving_reg;
        index_next     = index_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        ticks_next     = ticks_reg;
        id_next        = id_reg;
        err_next       = err_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        res_valid      = 1'b0;
        res.timed_out    = 1'b0;
        res.checksum_ok  = 1'b0;
        res.device_id    = id_reg;
        res.length_field = len_reg;
        res.error_byte   = err_reg;
        res.first_param  = pa_reg;
        res.second_param = pb_reg;
        if (take) begin
            priority if (item.kind == sbsr_pkg::KIND_START) begin
                receiving_next = 1'b1;
                index_next     = '0;
                len_next       = '0;
                sum_next       = '0;
                ticks_next     = '0;
                id_next        = '0;
                err_next       = '0;
                pa_next        = '0;
                pb_next        = '0;
            end else if (receiving_reg && item.kind == sbsr_pkg::KIND_TICK) begin
                ticks_next = ticks_inc;
                if (ticks_inc > timeout_reg) begin
                    receiving_next = 1'b0;
                    res_valid      = 1'b1;
                    res.timed_out  = 1'b1;
                end
            end else if (receiving_reg && item.kind == sbsr_pkg::KIND_BYTE) begin
                ticks_next = '0;
                len_next   = len_eff;
                index_next = index_reg + 9'd1;
                if (index_reg >= sbsr_pkg::IDX_LEN && index_reg == last_index) begin
                    // Checksum byte closes the packet
                    receiving_next   = 1'b0;
                    res_valid        = 1'b1;
                    res.checksum_ok  = (sum_plus == sbsr_pkg::SUM_GOOD);
                    res.length_field = len_eff;
                end else begin
                    if (index_reg >= sbsr_pkg::IDX_ID) begin
                        sum_next = sum_plus;
                    end
                    if (index_reg == sbsr_pkg::IDX_ID) begin
                        id_next = item.rx_byte;
                    end
                    if (index_reg == sbsr_pkg::IDX_ERR) begin
                        err_next = item.rx_byte;
                    end
                    if (index_reg == sbsr_pkg::IDX_PARAM_A) begin
                        pa_next = item.rx_byte;
                    end
                    if (index_reg == sbsr_pkg::IDX_PARAM_B) begin
                        pb_next = item.rx_byte;
                    end
                end
            end else begin
                // drop bytes and ticks while idle, and the unused kind
                receiving_next = receiving_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            index_reg     <= '0;
            len_reg       <= '0;
            sum_reg       <= '0;
            ticks_reg     <= '0;
            id_reg        <= '0;
            err_reg       <= '0;
            pa_reg        <= '0;
            pb_reg        <= '0;
        end else begin
            receiving_reg <= receiving_next;
            index_reg     <= index_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            ticks_reg     <= ticks_next;
            id_reg        <= id_next;
            err_reg       <= err_next;
            pa_reg        <= pa_next;
            pb_reg        <= pb_next;
        end
    end

    // Timeout register, written from the configuration channel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= sbsr_pkg::TIMEOUT_RESET;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/sbsr_out_reg.sv -----
// Result register of the servo-bus status receiver: holds one result word
// until the master side takes it. Depends on sbsr_pkg.
`default_nettype none

module sbsr_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              res_valid,
    input  wire sbsr_pkg::result_t res,
    output logic                   space,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output sbsr_pkg::result_t      m_res
);

    logic              valid_reg, valid_next;
    sbsr_pkg::result_t res_reg;

    // Room for a new word when empty or when the held one leaves now
    assign space      = !valid_reg || m_tready;
    assign valid_next = res_valid || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

`default_nettype wire

// ----- design/servo_bus_status_receiver.sv -----
// Top level of the servo-bus status receiver: input register, packet core
// and result register. Depends on sbsr_pkg, sbsr_in_stage, sbsr_core, sbsr_out_reg.
`default_nettype none

// Receives one servo-bus status packet after a start word (tuser kind 0).
// Byte words (kind 1) are numbered from 0; byte 3 is the length L and byte
// L+3 the checksum, which closes the packet with one result word. Tick words
// (kind 2) count idle milliseconds; more than timeout_ticks of them in a row
// end reception with a timeout result. Each input word passes through the
// combinational packet core between the input and result registers, so one
// word is accepted every cycle; the core stalls only while the result register
// holds a word the master side has not taken. The timeout register (reset
// 1000) is written on the cfg channel, always ready; the user must write it
// only while no packet work is outstanding; the block does not enforce it.
module servo_bus_status_receiver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,     // timeout_ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // [7:0] rx_byte
    input  wire logic [1:0]  s_tuser,      // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,      // [7:0] device_id, [15:8] length_field,
                                           // [23:16] error_byte, [31:24] first_param,
                                           // [39:32] second_param
    output logic [1:0]       m_tuser       // [0] timed_out, [1] checksum_ok
);

    sbsr_pkg::item_t   s_item;
    sbsr_pkg::item_t   item;
    sbsr_pkg::result_t res;
    sbsr_pkg::result_t m_res;
    logic              item_valid;
    logic              space;
    logic              take;
    logic              res_valid;

    assign cfg_ready      = 1'b1;
    assign s_item.kind    = s_tuser;
    assign s_item.rx_byte = s_tdata;

    // Advance the held word whenever the result register has room
    assign take = item_valid && space;

    sbsr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sbsr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    sbsr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {m_res.second_param, m_res.first_param, m_res.error_byte,
                      m_res.length_field, m_res.device_id};
    assign m_tuser = {m_res.checksum_ok, m_res.timed_out};

endmodule

`default_nettype wire

// ----- bench/tb_servo_bus_status_receiver.sv -----
// Self-checking bench for servo_bus_status_receiver: a directed table, then random
// status packets, tick bursts and noise under several timeouts and flow patterns.
// Depends on sbsr_pkg and the receiver RTL only.

module tb_servo_bus_status_receiver;

    import sbsr_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         PHASE_WORDS = 52;
    localparam result_t    BLANK_TIMEOUT = {1'b1, 1'b0, 40'h0};
    localparam result_t    ZERO_LEN_GOOD = {1'b0, 1'b1, 8'hFF, 8'h00, 24'h0};

    typedef enum {ROW_WORD, ROW_TICKS, ROW_CFG} row_op_t;

    typedef struct {
        row_op_t    op;
        logic [1:0] kind;
        logic [15:0] arg;       // byte, tick count or register value
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] rx_byte
    logic [1:0]  s_tuser   = '0;     // [1:0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;            // device_id, length_field, error_byte,
                                     // first_param, second_param
    logic [1:0]  m_tuser;            // [0] timed_out, [1] checksum_ok

    // Receiver model state
    bit          rx_active     = 1'b0;
    logic [8:0]  next_index    = '0;
    logic [7:0]  len_byte      = '0;
    logic [7:0]  sum_acc       = '0;
    logic [15:0] tick_count    = '0;
    logic [7:0]  cap_id        = '0;
    logic [7:0]  cap_err       = '0;
    logic [7:0]  cap_pa        = '0;
    logic [7:0]  cap_pb        = '0;
    logic [15:0] timeout_limit = TIMEOUT_RESET;

    result_t     status_due[$];
    int          mismatches  = 0;
    int          words_sent  = 0;
    int          quiet_count = 0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;

    // Opening table: ignored words, reset timeout, length zero, restart,
    // short packet with a long tick gap, zero timeout
    dir_row_t opening_rows [24] = '{
        '{ROW_WORD,  KIND_TICK,   16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h00AB, 1'b0, '0},
        '{ROW_WORD,  KIND_UNUSED, 16'h00FF, 1'b0, '0},
        '{ROW_WORD,  KIND_START,  16'h0000, 1'b0, '0},
        '{ROW_TICKS, KIND_TICK,   16'd1000, 1'b0, '0},
        '{ROW_WORD,  KIND_TICK,   16'h0000, 1'b1, BLANK_TIMEOUT},
        '{ROW_WORD,  KIND_START,  16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h00FF, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h00FF, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h00FF, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0000, 1'b1, ZERO_LEN_GOOD},
        '{ROW_CFG,   KIND_START,  16'hFFFF, 1'b0, '0},
        '{ROW_WORD,  KIND_START,  16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_START,  16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0012, 1'b0, '0},
        '{ROW_TICKS, KIND_TICK,   16'd30,   1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0001, 1'b0, '0},
        '{ROW_WORD,  KIND_BYTE,   16'h0000, 1'b0, '0},
        '{ROW_CFG,   KIND_START,  16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_START,  16'h0000, 1'b0, '0},
        '{ROW_WORD,  KIND_TICK,   16'h0000, 1'b1, BLANK_TIMEOUT}
    };

    servo_bus_status_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Snapshot the captured bytes into a status word
    function automatic result_t status_snapshot(input bit tmo, input bit ok);
        result_t r;
        r.timed_out    = tmo;
        r.checksum_ok  = ok;
        r.device_id    = cap_id;
        r.length_field = len_byte;
        r.error_byte   = cap_err;
        r.first_param  = cap_pa;
        r.second_param = cap_pb;
        return r;
    endfunction

    // Advance the receiver model by one word; return 1 when it closes a packet
    function automatic bit decode_status_word(input logic [1:0] k, input logic [7:0] b,
                                              output result_t r);
        logic [7:0] total;
        r = '0;
        if (k == KIND_START) begin
            next_index = '0;
            len_byte   = '0;
            sum_acc    = '0;
            tick_count = '0;
            cap_id     = '0;
            cap_err    = '0;
            cap_pa     = '0;
            cap_pb     = '0;
            rx_active  = 1'b1;
            return 1'b0;
        end
        if (!rx_active)
            return 1'b0;
        if (k == KIND_TICK) begin
            if (tick_count != TICKS_MAX)
                tick_count = tick_count + 16'd1;
            if (tick_count > timeout_limit) begin
                rx_active = 1'b0;
                r = status_snapshot(1'b1, 1'b0);
                return 1'b1;
            end
            return 1'b0;
        end
        if (k != KIND_BYTE)
            return 1'b0;

        tick_count = '0;
        if (next_index == IDX_LEN)
            len_byte = b;
        if (next_index >= IDX_LEN && next_index == ({1'b0, len_byte} + IDX_LEN)) begin
            total      = sum_acc + b;
            rx_active  = 1'b0;
            next_index = next_index + 9'd1;
            r = status_snapshot(1'b0, total == SUM_GOOD);
            return 1'b1;
        end
        if (next_index >= IDX_ID)
            sum_acc = sum_acc + b;
        case (next_index)
            IDX_ID:      cap_id  = b;
            IDX_ERR:     cap_err = b;
            IDX_PARAM_A: cap_pa  = b;
            IDX_PARAM_B: cap_pb  = b;
            default: ;
        endcase
        next_index = next_index + 9'd1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void note_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Drive one word from a falling edge; hold valid high on return
    task automatic push_word(input logic [1:0] k, input logic [7:0] b,
                             input bit typed = 1'b0, input result_t want = '0);
        result_t res;
        bit      hit;
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        hit = decode_status_word(k, b, res);
        if (typed)
            status_due.push_back(want);
        else if (hit)
            status_due.push_back(res);
        words_sent++;
        @(negedge aclk);
    endtask

    // Write the timeout register once all results are in and the core is quiet
    task automatic write_timeout(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        timeout_limit = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One status packet; unless clean, may carry bad header or checksum, tick
    // bursts near a timeout of at most 64 (else 1 to 4 ticks), or be cut short
    task automatic send_packet_run(input bit clean);
        logic [7:0]  frame[$];
        logic [7:0]  sum;
        int unsigned len;
        int unsigned cut;
        int unsigned burst;
        int unsigned pick;
        frame = {};
        repeat (2) frame.push_back((clean || $urandom_range(9) != 0) ? 8'hFF : rand_byte());
        pick = $urandom_range(99);
        if (pick < 2)
            len = $urandom_range(128, 255);
        else if (pick < 12)
            len = $urandom_range(7, 40);
        else
            len = $urandom_range(0, 6);
        frame.push_back(rand_byte());
        frame.push_back(8'(len));
        repeat (len) frame.push_back(rand_byte());
        sum = '0;
        for (int i = 2; i < frame.size(); i++)
            sum = sum + frame[i];
        frame.push_back((clean || $urandom_range(3) != 0) ? ~sum : rand_byte());
        cut = (!clean && $urandom_range(9) == 0) ? $urandom_range(frame.size() - 1)
                                                  : frame.size();

        push_word(KIND_START, rand_byte());
        for (int i = 0; i < cut; i++) begin
            if (!clean && $urandom_range(9) == 0) begin
                if (timeout_limit <= 16'd64)
                    burst = $urandom_range(1) ? timeout_limit : timeout_limit + 1;
                else
                    burst = $urandom_range(1, 4);
                repeat (burst) push_word(KIND_TICK, rand_byte());
                // drop the rest once the gap has ended reception
                if (!rx_active)
                    return;
            end
            push_word(KIND_BYTE, frame[i]);
        end
    endtask

    // Main sequence
    initial begin
        int unsigned base;
        logic [15:0] phase_tmo [8];
        phase_tmo = '{16'd3, 16'd0, 16'hFFFF, 16'd17, 16'd1, 16'd200, 16'd40, TIMEOUT_RESET};

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_rows[i]) begin
            case (opening_rows[i].op)
                ROW_WORD:  push_word(opening_rows[i].kind, opening_rows[i].arg[7:0],
                                     opening_rows[i].typed, opening_rows[i].want);
                ROW_TICKS: repeat (opening_rows[i].arg) push_word(KIND_TICK, 8'h00);
                ROW_CFG:   write_timeout(opening_rows[i].arg);
                default: ;
            endcase
        end

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 62; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 62; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            if (p == 6)
                phase_tmo[p] = 16'($urandom_range(2, 60));
            write_timeout(phase_tmo[p]);
            base = words_sent;
            while (words_sent - base < PHASE_WORDS) begin
                if ($urandom_range(9) == 0)
                    repeat ($urandom_range(1, 4))
                        push_word(2'($urandom_range(3)), 8'($urandom_range(255)));
                else
                    send_packet_run(1'b0);
            end
            // close the phase on a complete packet so the receiver is idle
            send_packet_run(1'b1);
        end

        s_tvalid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each result word with the oldest expected status
    always @(posedge aclk) begin : status_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[0], m_tuser[1], m_tdata[7:0], m_tdata[15:8],
                   m_tdata[23:16], m_tdata[31:24], m_tdata[39:32]};
            if (status_due.size() == 0) begin
                $error("unexpected status word %0h", got);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                note_field("timed_out", 8'(want.timed_out), 8'(got.timed_out));
                note_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
                note_field("device_id", want.device_id, got.device_id);
                note_field("length_field", want.length_field, got.length_field);
                note_field("error_byte", want.error_byte, got.error_byte);
                note_field("first_param", want.first_param, got.first_param);
                note_field("second_param", want.second_param, got.second_param);
            end
        end
    end

    // Watchdog: end the run when no word moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

endmodule
